[hdl/moi_pkg.sv]
// Shared types, constants and the arctangent table of the odometry integrator.
`timescale 1ns / 1ps
`default_nettype none

package moi_pkg;

    // Field and datapath widths.
    localparam int WHEEL_W     = 16;
    localparam int SUM_W       = 18;
    localparam int GAIN_W      = 32;
    localparam int PROD_W      = SUM_W + GAIN_W + 1;
    localparam int POSE_W      = 32;
    localparam int ANGLE_W     = 32;
    localparam int CW          = 18;
    localparam int MIX_W       = SUM_W + CW + 2;
    localparam int CORDIC_FRAC = 14;
    localparam int DELTA_W     = MIX_W - CORDIC_FRAC;
    localparam int MIX_ROUND   = 8192;

    // CORDIC iteration count, limited to the length of the arctangent table.
    localparam int CORDIC_STEPS  = 16;
    localparam int ATAN_ENTRIES  = 24;
    localparam int CORDIC_ITERS  = (CORDIC_STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STEPS;
    localparam int ITER_W        = $clog2(CORDIC_ITERS);
    localparam int ATAN_IDX_W    = 5;
    localparam int CORDIC_START  = 9949;

    // Rounding offsets for the gain products.
    localparam logic [PROD_W-1:0] ROUND_HI = {{(PROD_W-32){1'b0}}, 32'h8000_0000};
    localparam logic [PROD_W-1:0] ROUND_LO = {{(PROD_W-16){1'b0}}, 16'h8000};

    // Heading fold limits and the half-turn shift.
    localparam logic [ANGLE_W-1:0] QUARTER_TURN       = 32'h4000_0000;
    localparam logic [ANGLE_W-1:0] THREE_QUARTER_TURN = 32'hC000_0000;
    localparam logic [ANGLE_W-1:0] HALF_TURN          = 32'h8000_0000;

    // Step queue depth.
    localparam int FIFO_PTR_W = 1;
    localparam int FIFO_DEPTH = 2 ** FIFO_PTR_W;

    // Configuration port.
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 32;
    localparam logic [GAIN_W-1:0] LINEAR_GAIN_RESET  = 32'd875069000;
    localparam logic [GAIN_W-1:0] ANGULAR_GAIN_RESET = 32'd316526400;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_LINEAR_GAIN  = 1'b0,
        REG_ANGULAR_GAIN = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic [GAIN_W-1:0] linear;
        logic [GAIN_W-1:0] angular;
    } gains_t;

    // Body-frame step handed from the front end to the integrator.
    typedef struct packed {
        logic signed [SUM_W-1:0] fwd;
        logic signed [SUM_W-1:0] lat;
        logic [ANGLE_W-1:0]      turn;
    } step_t;

    typedef enum logic [2:0] {
        F_IDLE,
        F_MUL_F,
        F_MUL_L,
        F_MUL_T,
        F_ROUND_T,
        F_PUSH
    } front_state_t;

    typedef enum logic [3:0] {
        B_IDLE,
        B_ROT,
        B_FIX,
        B_MUL0,
        B_MUL1,
        B_MUL2,
        B_MUL3,
        B_MUL4,
        B_ROUND,
        B_UPDATE
    } back_state_t;

    // Arctangent of 2^-i in binary angle units, 2^32 per turn.
    function automatic logic [ANGLE_W-1:0] atan_turn(input logic [ATAN_IDX_W-1:0] idx);
        logic [ANGLE_W-1:0] v;
        case (idx)
            5'd0:    v = 32'd536870912;
            5'd1:    v = 32'd316933406;
            5'd2:    v = 32'd167458907;
            5'd3:    v = 32'd85004756;
            5'd4:    v = 32'd42667331;
            5'd5:    v = 32'd21354465;
            5'd6:    v = 32'd10679838;
            5'd7:    v = 32'd5340245;
            5'd8:    v = 32'd2670163;
            5'd9:    v = 32'd1335087;
            5'd10:   v = 32'd667544;
            5'd11:   v = 32'd333772;
            5'd12:   v = 32'd166886;
            5'd13:   v = 32'd83443;
            5'd14:   v = 32'd41722;
            5'd15:   v = 32'd20861;
            5'd16:   v = 32'd10430;
            5'd17:   v = 32'd5215;
            5'd18:   v = 32'd2608;
            5'd19:   v = 32'd1304;
            5'd20:   v = 32'd652;
            5'd21:   v = 32'd326;
            5'd22:   v = 32'd163;
            5'd23:   v = 32'd81;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

[hdl/moi_stream_if.sv]
// Valid/ready stream interfaces for the wheel samples and the pose results.
`timescale 1ns / 1ps
`default_nettype none

interface moi_sample_if;
    import moi_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [WHEEL_W-1:0] wheel_front_left;
    logic signed [WHEEL_W-1:0] wheel_front_right;
    logic signed [WHEEL_W-1:0] wheel_rear_left;
    logic signed [WHEEL_W-1:0] wheel_rear_right;

    modport source (
        output valid, wheel_front_left, wheel_front_right, wheel_rear_left, wheel_rear_right,
        input  ready
    );
    modport sink (
        input  valid, wheel_front_left, wheel_front_right, wheel_rear_left, wheel_rear_right,
        output ready
    );
endinterface

interface moi_result_if;
    import moi_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [POSE_W-1:0] pose_x;
    logic signed [POSE_W-1:0] pose_y;
    logic [ANGLE_W-1:0]       pose_heading;
    logic signed [POSE_W-1:0] step_forward;
    logic signed [POSE_W-1:0] step_lateral;
    logic signed [POSE_W-1:0] step_turn;

    modport source (
        output valid, pose_x, pose_y, pose_heading, step_forward, step_lateral, step_turn,
        input  ready
    );
    modport sink (
        input  valid, pose_x, pose_y, pose_heading, step_forward, step_lateral, step_turn,
        output ready
    );
endinterface

`default_nettype wire

[hdl/mecanum_odometry_integrator_top.sv]
// Top level of the mecanum odometry integrator: gain registers, front end, queue, back end.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Role    Word
// sample    sink    four signed 16-bit wheel count deltas
// result    source  pose x, y, heading and the body steps of this sample
// cfg       write   gain register index and 32-bit data, no read-back
//
// The front end takes a word only after it has pushed the last one into the queue; the
// back end takes the next word from the queue only once it is through with the last,
// its pace set by the one-step-per-cycle CORDIC and the shared rotation multiplier.
// Reset clears the pose, the queue and the gains to their defaults at once.
// A stalled result holds the back end; the queue and the front end still take up to three
// more words before the input stalls.

module mecanum_odometry_integrator_top (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [moi_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [moi_pkg::CFG_DATA_W-1:0]  cfg_data,
    moi_sample_if.sink                           sample,
    moi_result_if.source                         result
);
    import moi_pkg::*;

    gains_t gains_reg;
    logic   push_valid;
    logic   push_ready;
    step_t  push_data;
    logic   pop_valid;
    logic   pop_ready;
    step_t  pop_data;

    // Gain registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gains_reg.linear  <= LINEAR_GAIN_RESET;
            gains_reg.angular <= ANGULAR_GAIN_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_LINEAR_GAIN:  gains_reg.linear  <= cfg_data;
                REG_ANGULAR_GAIN: gains_reg.angular <= cfg_data;
                default:          ;
            endcase
        end
    end

    moi_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .gains      (gains_reg),
        .sample     (sample),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    moi_step_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    moi_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .result    (result)
    );

endmodule

`default_nettype wire

[hdl/moi_front.sv]
// Front end: takes wheel words, forms the kinematic sums and scales them by the gains.
`timescale 1ns / 1ps
`default_nettype none

module moi_front (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire moi_pkg::gains_t gains,
    moi_sample_if.sink           sample,
    output logic                 push_valid,
    input  wire logic            push_ready,
    output moi_pkg::step_t       push_data
);
    import moi_pkg::*;

    front_state_t state_reg;
    front_state_t state_next;

    logic signed [SUM_W-1:0]  sum_f_reg;
    logic signed [SUM_W-1:0]  sum_l_reg;
    logic signed [SUM_W-1:0]  sum_t_reg;
    logic signed [PROD_W-1:0] prod_reg;
    step_t                    step_reg;

    logic signed [SUM_W-1:0]  fl;
    logic signed [SUM_W-1:0]  fr;
    logic signed [SUM_W-1:0]  rl;
    logic signed [SUM_W-1:0]  rr;
    logic signed [SUM_W-1:0]  mul_a;
    logic [GAIN_W-1:0]        mul_gain;
    logic signed [GAIN_W:0]   mul_b;
    logic signed [PROD_W-1:0] product;
    logic [PROD_W-1:0]        rnd_hi;
    logic [PROD_W-1:0]        rnd_lo;
    logic                     accept;

    // Wheel words widened for the signed sums.
    assign fl = SUM_W'(sample.wheel_front_left);
    assign fr = SUM_W'(sample.wheel_front_right);
    assign rl = SUM_W'(sample.wheel_rear_left);
    assign rr = SUM_W'(sample.wheel_rear_right);

    assign sample.ready = (state_reg == F_IDLE);
    assign accept       = sample.valid && (state_reg == F_IDLE);
    assign push_valid   = (state_reg == F_PUSH);
    assign push_data    = step_reg;

    // One shared multiplier walks through the three gain products.
    always_comb
    begin
        case (state_reg)
            F_MUL_L:
            begin
                mul_a    = sum_l_reg;
                mul_gain = gains.linear;
            end
            F_MUL_T:
            begin
                mul_a    = sum_t_reg;
                mul_gain = gains.angular;
            end
            default:
            begin
                mul_a    = sum_f_reg;
                mul_gain = gains.linear;
            end
        endcase
        mul_b   = $signed({1'b0, mul_gain});
        product = mul_a * mul_b;
        rnd_hi  = prod_reg + ROUND_HI;
        rnd_lo  = prod_reg + ROUND_LO;
    end

    // Sequencer for the front end.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE:    if (sample.valid) state_next = F_MUL_F;
            F_MUL_F:   state_next = F_MUL_L;
            F_MUL_L:   state_next = F_MUL_T;
            F_MUL_T:   state_next = F_ROUND_T;
            F_ROUND_T: state_next = F_PUSH;
            F_PUSH:    if (push_ready) state_next = F_IDLE;
            default:   state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Sums on accept, then rounded products one state behind the multiplier.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sum_f_reg <= fl + fr + rl + rr;
            sum_l_reg <= fr + rl - fl - rr;
            sum_t_reg <= fr + rr - fl - rl;
        end
        prod_reg <= product;
        case (state_reg)
            F_MUL_L:   step_reg.fwd  <= rnd_hi[32 +: SUM_W];
            F_MUL_T:   step_reg.lat  <= rnd_hi[32 +: SUM_W];
            F_ROUND_T: step_reg.turn <= rnd_lo[16 +: ANGLE_W];
            default:   ;
        endcase
    end

endmodule

`default_nettype wire

[hdl/moi_step_fifo.sv]
// Short queue of body-frame steps between the front end and the integrator.
`timescale 1ns / 1ps
`default_nettype none

module moi_step_fifo (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push_valid,
    output logic                push_ready,
    input  wire moi_pkg::step_t push_data,
    output logic                pop_valid,
    input  wire logic           pop_ready,
    output moi_pkg::step_t      pop_data
);
    import moi_pkg::*;

    step_t                 mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [FIFO_PTR_W:0]   count_reg;
    logic                  do_push;
    logic                  do_pop;

    assign push_ready = (count_reg != (FIFO_PTR_W + 1)'(FIFO_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

[hdl/moi_back.sv]
// Back end: CORDIC of the kept heading, world-frame rotation and pose update.
`timescale 1ns / 1ps
`default_nettype none

module moi_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           pop_valid,
    output logic                pop_ready,
    input  wire moi_pkg::step_t pop_data,
    moi_result_if.source        result
);
    import moi_pkg::*;

    back_state_t state_reg;
    back_state_t state_next;

    step_t                     step_reg;
    logic signed [CW-1:0]      x_reg;
    logic signed [CW-1:0]      y_reg;
    logic [ANGLE_W-1:0]        z_reg;
    logic                      flip_reg;
    logic [ITER_W-1:0]         iter_reg;
    logic signed [SUM_W+CW-1:0] mul_reg;
    logic signed [MIX_W-1:0]   mix_x_reg;
    logic signed [MIX_W-1:0]   mix_y_reg;
    logic signed [DELTA_W-1:0] dx_reg;
    logic signed [DELTA_W-1:0] dy_reg;
    logic signed [POSE_W-1:0]  acc_x_reg;
    logic signed [POSE_W-1:0]  acc_y_reg;
    logic [ANGLE_W-1:0]        acc_heading_reg;
    logic                      res_valid_reg;
    logic signed [POSE_W-1:0]  res_x_reg;
    logic signed [POSE_W-1:0]  res_y_reg;
    logic [ANGLE_W-1:0]        res_heading_reg;
    logic signed [POSE_W-1:0]  res_fwd_reg;
    logic signed [POSE_W-1:0]  res_lat_reg;
    logic [ANGLE_W-1:0]        res_turn_reg;

    logic                      fold;
    logic                      last_iter;
    logic signed [CW-1:0]      x_sh;
    logic signed [CW-1:0]      y_sh;
    logic signed [CW-1:0]      x_rot;
    logic signed [CW-1:0]      y_rot;
    logic [ANGLE_W-1:0]        z_rot;
    logic [ANGLE_W-1:0]        atan_val;
    logic signed [SUM_W-1:0]   mul_a;
    logic signed [CW-1:0]      mul_b;
    logic signed [MIX_W-1:0]   mul_ext;
    logic signed [MIX_W-1:0]   rnd_x;
    logic signed [MIX_W-1:0]   rnd_y;
    logic signed [POSE_W:0]    sum_x;
    logic signed [POSE_W:0]    sum_y;
    logic signed [POSE_W-1:0]  new_x;
    logic signed [POSE_W-1:0]  new_y;
    logic                      fire;

    // Fold the kept heading into the right half plane.
    assign fold = (acc_heading_reg > QUARTER_TURN) && (acc_heading_reg < THREE_QUARTER_TURN);

    // One CORDIC micro-rotation per cycle.
    always_comb
    begin
        atan_val  = atan_turn(ATAN_IDX_W'(iter_reg));
        x_sh      = x_reg >>> iter_reg;
        y_sh      = y_reg >>> iter_reg;
        last_iter = (iter_reg == ITER_W'(CORDIC_ITERS - 1));
        if (!z_reg[ANGLE_W-1])
        begin
            x_rot = x_reg - y_sh;
            y_rot = y_reg + x_sh;
            z_rot = z_reg - atan_val;
        end
        else
        begin
            x_rot = x_reg + y_sh;
            y_rot = y_reg - x_sh;
            z_rot = z_reg + atan_val;
        end
    end

    // Shared multiplier for the four rotation products.
    always_comb
    begin
        case (state_reg)
            B_MUL1:
            begin
                mul_a = step_reg.lat;
                mul_b = y_reg;
            end
            B_MUL2:
            begin
                mul_a = step_reg.fwd;
                mul_b = y_reg;
            end
            B_MUL3:
            begin
                mul_a = step_reg.lat;
                mul_b = x_reg;
            end
            default:
            begin
                mul_a = step_reg.fwd;
                mul_b = x_reg;
            end
        endcase
        mul_ext = MIX_W'(mul_reg);
        rnd_x   = mix_x_reg + MIX_W'(MIX_ROUND);
        rnd_y   = mix_y_reg + MIX_W'(MIX_ROUND);
    end

    // Saturating position sums.
    always_comb
    begin
        sum_x = {acc_x_reg[POSE_W-1], acc_x_reg}
              + {{(POSE_W + 1 - DELTA_W){dx_reg[DELTA_W-1]}}, dx_reg};
        sum_y = {acc_y_reg[POSE_W-1], acc_y_reg}
              + {{(POSE_W + 1 - DELTA_W){dy_reg[DELTA_W-1]}}, dy_reg};
        if (sum_x[POSE_W] != sum_x[POSE_W-1])
        begin
            new_x = sum_x[POSE_W] ? {1'b1, {(POSE_W-1){1'b0}}} : {1'b0, {(POSE_W-1){1'b1}}};
        end
        else
        begin
            new_x = sum_x[POSE_W-1:0];
        end
        if (sum_y[POSE_W] != sum_y[POSE_W-1])
        begin
            new_y = sum_y[POSE_W] ? {1'b1, {(POSE_W-1){1'b0}}} : {1'b0, {(POSE_W-1){1'b1}}};
        end
        else
        begin
            new_y = sum_y[POSE_W-1:0];
        end
    end

    // Sequencer for the back end.
    always_comb
    begin
        state_next = state_reg;
        pop_ready  = 1'b0;
        fire       = 1'b0;
        unique case (state_reg)
            B_IDLE:
            begin
                pop_ready = 1'b1;
                if (pop_valid) state_next = B_ROT;
            end
            B_ROT:    if (last_iter) state_next = B_FIX;
            B_FIX:    state_next = B_MUL0;
            B_MUL0:   state_next = B_MUL1;
            B_MUL1:   state_next = B_MUL2;
            B_MUL2:   state_next = B_MUL3;
            B_MUL3:   state_next = B_MUL4;
            B_MUL4:   state_next = B_ROUND;
            B_ROUND:  state_next = B_UPDATE;
            B_UPDATE:
            begin
                if (!res_valid_reg || result.ready)
                begin
                    fire       = 1'b1;
                    state_next = B_IDLE;
                end
            end
            default:  state_next = B_IDLE;
        endcase
    end

    // Control state, kept pose and result handshake.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= B_IDLE;
            acc_x_reg       <= '0;
            acc_y_reg       <= '0;
            acc_heading_reg <= '0;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (fire)
            begin
                acc_x_reg       <= new_x;
                acc_y_reg       <= new_y;
                acc_heading_reg <= acc_heading_reg + step_reg.turn;
                res_valid_reg   <= 1'b1;
            end
            else if (result.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        mul_reg <= mul_a * mul_b;
        case (state_reg)
            B_IDLE:
            begin
                step_reg <= pop_data;
                x_reg    <= CW'(CORDIC_START);
                y_reg    <= '0;
                z_reg    <= fold ? acc_heading_reg + HALF_TURN : acc_heading_reg;
                flip_reg <= fold;
                iter_reg <= '0;
            end
            B_ROT:
            begin
                x_reg    <= x_rot;
                y_reg    <= y_rot;
                z_reg    <= z_rot;
                iter_reg <= iter_reg + 1'b1;
            end
            B_FIX:
            begin
                if (flip_reg)
                begin
                    x_reg <= -x_reg;
                    y_reg <= -y_reg;
                end
            end
            B_MUL1:   mix_x_reg <= mul_ext;
            B_MUL2:   mix_x_reg <= mix_x_reg - mul_ext;
            B_MUL3:   mix_y_reg <= mul_ext;
            B_MUL4:   mix_y_reg <= mix_y_reg + mul_ext;
            B_ROUND:
            begin
                dx_reg <= rnd_x[MIX_W-1:CORDIC_FRAC];
                dy_reg <= rnd_y[MIX_W-1:CORDIC_FRAC];
            end
            default:  ;
        endcase
        if (fire)
        begin
            res_x_reg       <= new_x;
            res_y_reg       <= new_y;
            res_heading_reg <= acc_heading_reg + step_reg.turn;
            res_fwd_reg     <= POSE_W'(step_reg.fwd);
            res_lat_reg     <= POSE_W'(step_reg.lat);
            res_turn_reg    <= step_reg.turn;
        end
    end

    assign result.valid        = res_valid_reg;
    assign result.pose_x       = res_x_reg;
    assign result.pose_y       = res_y_reg;
    assign result.pose_heading = res_heading_reg;
    assign result.step_forward = res_fwd_reg;
    assign result.step_lateral = res_lat_reg;
    assign result.step_turn    = $signed(res_turn_reg);

endmodule

`default_nettype wire

[tb/testbench.sv]
// Self-checking testbench for the mecanum odometry integrator: pose prediction and stream checks.
`timescale 1ns / 1ps

module testbench;
    import moi_pkg::*;

    localparam int CLK_PERIOD    = 10;
    localparam int RESET_CYCLES  = 7;
    localparam int SETTLE_CYCLES = 60;
    localparam int TIMEOUT_NS    = 30_000_000;
    localparam int RANDOM_WORDS  = 800;
    localparam int GAIN_SETTINGS = 5;
    localparam int HOLD_CYCLES   = 400;

    localparam int POS_TOP    = 32'sh7FFF_FFFF;
    localparam int POS_BOTTOM = 32'sh8000_0000;

    localparam logic [31:0] GAIN_MAX         = 32'hFFFF_FFFF;
    // With these angular gains a yaw sum of k gives k * 2^15 or exactly k heading units.
    localparam logic [31:0] COARSE_TURN_GAIN = 32'h8000_0000;
    localparam logic [31:0] FINE_TURN_GAIN   = 32'h0001_0000;
    localparam logic [31:0] DIAGONAL_HEADING = 32'hE000_0000;

    // Arctangent of 2^-i, one full turn is 2^32.
    localparam logic [31:0] ARCTAN_TURNS [0:23] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
        32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722,
        32'd20861, 32'd10430, 32'd5215, 32'd2608, 32'd1304,
        32'd652, 32'd326, 32'd163, 32'd81
    };

    // Headings on both sides of the quarter-turn fold of the sine and cosine.
    localparam logic [31:0] FOLD_EDGES [0:4] = '{
        QUARTER_TURN, QUARTER_TURN + 32'd1, HALF_TURN,
        THREE_QUARTER_TURN - 32'd1, THREE_QUARTER_TURN
    };

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] heading;
        logic [31:0] fwd;
        logic [31:0] lat;
        logic [31:0] turn;
    } pose_word_t;

    // Keeps its own pose and gains, predicts each pose word and checks the ones that come out.
    class pose_tracker;
        logic [31:0] lin_gain;
        logic [31:0] ang_gain;
        int          pos_x;
        int          pos_y;
        logic [31:0] heading;
        int          mismatches;
        int          words_seen;
        int          x_clamps;
        int          y_clamps;
        pose_word_t  expected_poses[$];

        function new();
            lin_gain   = LINEAR_GAIN_RESET;
            ang_gain   = ANGULAR_GAIN_RESET;
            pos_x      = 0;
            pos_y      = 0;
            heading    = '0;
            mismatches = 0;
            words_seen = 0;
            x_clamps   = 0;
            y_clamps   = 0;
        endfunction

        function void load_gains(input logic [31:0] lin, input logic [31:0] ang);
            lin_gain = lin;
            ang_gain = ang;
        endfunction

        function int outstanding();
            return expected_poses.size();
        endfunction

        // Cosine and sine in Q2.14 from a rotation-mode CORDIC, folded by a half turn.
        function void heading_cos_sin(input logic [31:0] angle, output longint c,
                                      output longint s);
            logic [31:0] z;
            longint      x;
            longint      y;
            longint      nx;
            bit          flip;
            int          i;
            z    = angle;
            flip = 1'b0;
            if (z > QUARTER_TURN && z < THREE_QUARTER_TURN)
            begin
                z    = z + HALF_TURN;
                flip = 1'b1;
            end
            x = CORDIC_START;
            y = 0;
            for (i = 0; i < CORDIC_ITERS; i++)
            begin
                if (z[31] == 1'b0)
                begin
                    nx = x - (y >>> i);
                    y  = y + (x >>> i);
                    z  = z - ARCTAN_TURNS[i];
                end
                else
                begin
                    nx = x + (y >>> i);
                    y  = y - (x >>> i);
                    z  = z + ARCTAN_TURNS[i];
                end
                x = nx;
            end
            c = flip ? -x : x;
            s = flip ? -y : y;
        endfunction

        function int clamp_pose(input longint v);
            if (v > longint'(POS_TOP))
                return POS_TOP;
            if (v < longint'(POS_BOTTOM))
                return POS_BOTTOM;
            return int'(v);
        endfunction

        // Advance the pose by one accepted wheel word and queue the pose word it must give.
        function void take_sample(input logic signed [15:0] fl, fr, rl, rr);
            longint     sum_f;
            longint     sum_l;
            longint     sum_t;
            longint     fwd;
            longint     lat;
            longint     turn_wide;
            longint     c;
            longint     s;
            longint     dx;
            longint     dy;
            longint     nx;
            longint     ny;
            pose_word_t w;
            sum_f = longint'(fl) + longint'(fr) + longint'(rl) + longint'(rr);
            sum_l = longint'(fr) + longint'(rl) - longint'(fl) - longint'(rr);
            sum_t = longint'(fr) + longint'(rr) - longint'(fl) - longint'(rl);
            fwd = (sum_f * longint'({32'd0, lin_gain}) + 64'sh8000_0000) >>> 32;
            lat = (sum_l * longint'({32'd0, lin_gain}) + 64'sh8000_0000) >>> 32;
            turn_wide = (sum_t * longint'({32'd0, ang_gain}) + 64'sh8000) >>> 16;

            // Rotate by the heading held before this word.
            heading_cos_sin(heading, c, s);
            dx = (fwd * c - lat * s + 64'sd8192) >>> 14;
            dy = (fwd * s + lat * c + 64'sd8192) >>> 14;
            nx = longint'(pos_x) + dx;
            ny = longint'(pos_y) + dy;
            pos_x = clamp_pose(nx);
            pos_y = clamp_pose(ny);
            if (longint'(pos_x) != nx)
                x_clamps++;
            if (longint'(pos_y) != ny)
                y_clamps++;
            heading = heading + 32'(turn_wide);

            w.x       = pos_x;
            w.y       = pos_y;
            w.heading = heading;
            w.fwd     = 32'(fwd);
            w.lat     = 32'(lat);
            w.turn    = 32'(turn_wide);
            expected_poses.push_back(w);
        endfunction

        function void check_field(input string name, input logic [31:0] want,
                                  input logic [31:0] got);
            if (got !== want)
            begin
                mismatches++;
                $display("%0t: %s expected %h actual %h", $time, name, want, got);
            end
        endfunction

        // Compare one pose word from the block with the oldest prediction.
        function void compare_pose(input pose_word_t got);
            pose_word_t want;
            if (expected_poses.size() == 0)
            begin
                mismatches++;
                $display("%0t: pose word x=%h y=%h arrived with none outstanding",
                         $time, got.x, got.y);
                return;
            end
            want = expected_poses.pop_front();
            words_seen++;
            check_field("pose_x", want.x, got.x);
            check_field("pose_y", want.y, got.y);
            check_field("pose_heading", want.heading, got.heading);
            check_field("step_forward", want.fwd, got.fwd);
            check_field("step_lateral", want.lat, got.lat);
            check_field("step_turn", want.turn, got.turn);
        endfunction
    endclass

    logic     clk;
    logic     rst_n;
    logic     cfg_we;
    cfg_reg_t cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    moi_sample_if sample_ch ();
    moi_result_if result_ch ();

    pose_tracker tracker = new();
    bit          idle_on;
    int          rx_hold_left;
    int          gain_settings;

    mecanum_odometry_integrator_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sample    (sample_ch),
        .result    (result_ch)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Hard limit on the run.
    initial
    begin
        #(TIMEOUT_NS);
        $display("RESULT: ERROR");
        $finish;
    end

    // Result side: check each accepted word, then pick ready for the next edge.
    initial
    begin
        int stall_left;
        stall_left = 0;
        result_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
                tracker.compare_pose({result_ch.pose_x, result_ch.pose_y,
                                      result_ch.pose_heading, result_ch.step_forward,
                                      result_ch.step_lateral, result_ch.step_turn});
            if (rx_hold_left > 0)
            begin
                rx_hold_left--;
                result_ch.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                result_ch.ready <= 1'b0;
            end
            else if (rst_n && idle_on && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(0, 2);
                result_ch.ready <= 1'b0;
            end
            else
                result_ch.ready <= rst_n;
        end
    end

    // Offer one wheel word, possibly after a short gap, and wait until it is taken.
    task automatic send_word(input logic signed [15:0] fl, fr, rl, rr);
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            sample_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        sample_ch.valid             <= 1'b1;
        sample_ch.wheel_front_left  <= fl;
        sample_ch.wheel_front_right <= fr;
        sample_ch.wheel_rear_left   <= rl;
        sample_ch.wheel_rear_right  <= rr;
        do
            @(posedge clk);
        while (sample_ch.ready !== 1'b1);
        tracker.take_sample(fl, fr, rl, rr);
    endtask

    // Stop offering and wait until every predicted pose word has come out.
    task automatic settle();
        sample_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (tracker.outstanding() != 0);
    endtask

    // Write both gain registers; the block must be idle.
    task automatic set_gains(input logic [31:0] lin, input logic [31:0] ang);
        cfg_we    <= 1'b1;
        cfg_index <= REG_LINEAR_GAIN;
        cfg_data  <= lin;
        @(posedge clk);
        cfg_index <= REG_ANGULAR_GAIN;
        cfg_data  <= ang;
        @(posedge clk);
        cfg_we <= 1'b0;
        tracker.load_gains(lin, ang);
        gain_settings++;
    endtask

    // A word whose yaw sum is k, built from the right wheels and, at the top of the range, the front left.
    task automatic send_yaw(input int k);
        int fl;
        int fr;
        int rr;
        fl = 0;
        fr = k >>> 1;
        rr = k - fr;
        if (rr > 32767)
        begin
            rr = 32767;
            fl = -1;
        end
        send_word(16'(fl), 16'(fr), 16'sd0, 16'(rr));
    endtask

    // Bring the heading exactly to a target with a coarse and a fine yaw word.
    task automatic steer_heading(input logic [31:0] target);
        logic [31:0] lin;
        logic [31:0] ang;
        logic [31:0] offset;
        int          coarse;
        int          fine;
        settle();
        lin    = tracker.lin_gain;
        ang    = tracker.ang_gain;
        offset = target - tracker.heading;
        coarse = $signed(offset) >>> 15;
        fine   = int'(offset[14:0]);
        set_gains(lin, COARSE_TURN_GAIN);
        send_yaw(coarse);
        settle();
        set_gains(lin, FINE_TURN_GAIN);
        send_yaw(fine);
        settle();
        set_gains(lin, ang);
    endtask

    // Random wheel word: mostly full range, some small counts, extremes and pure motions.
    task automatic send_random_word();
        logic signed [15:0] w [4];
        int style;
        int m;
        int i;
        style = $urandom_range(0, 9);
        m = $urandom_range(0, 32767);
        if ($urandom_range(0, 1) == 1)
            m = -m;
        for (i = 0; i < 4; i++)
        begin
            case (style)
                6, 7:
                    w[i] = 16'(int'($urandom_range(0, 600)) - 300);
                8:
                begin
                    case ($urandom_range(0, 3))
                        0:       w[i] = 16'sh7FFF;
                        1:       w[i] = 16'sh8000;
                        2:       w[i] = 16'sh0000;
                        default: w[i] = 16'shFFFF;
                    endcase
                end
                9:
                    w[i] = 16'(m);
                default:
                    w[i] = 16'($urandom);
            endcase
        end
        // Pure motions: forward keeps all equal, lateral and yaw flip two wheels.
        if (style == 9)
        begin
            case ($urandom_range(0, 2))
                0: ;
                1:
                begin
                    w[0] = -w[0];
                    w[3] = -w[3];
                end
                default:
                begin
                    w[0] = -w[0];
                    w[2] = -w[2];
                end
            endcase
        end
        send_word(w[0], w[1], w[2], w[3]);
    endtask

    // Stimulus: directed words, random phases over several gain settings, then a diagonal run.
    initial
    begin
        int          phase;
        int          n;
        logic [31:0] lin;
        logic [31:0] ang;
        rst_n                       = 1'b0;
        cfg_we                      = 1'b0;
        cfg_index                   = REG_LINEAR_GAIN;
        cfg_data                    = '0;
        sample_ch.valid             = 1'b0;
        sample_ch.wheel_front_left  = '0;
        sample_ch.wheel_front_right = '0;
        sample_ch.wheel_rear_left   = '0;
        sample_ch.wheel_rear_right  = '0;
        idle_on                     = 1'b1;
        rx_hold_left                = 0;
        gain_settings               = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Field extremes at the reset gains.
        send_word(16'sd0, 16'sd0, 16'sd0, 16'sd0);
        send_word(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
        send_word(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
        send_word(16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000);
        send_word(16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh8000);
        settle();

        // Gains that put each product exactly halfway between two outputs.
        set_gains(32'h8000_0000, 32'h0000_8000);
        send_word(16'sd1, 16'sd0, 16'sd0, 16'sd0);
        send_word(16'shFFFF, 16'sd0, 16'sd0, 16'sd0);
        settle();

        // Rotation right at and next to the fold edges, with the largest gains.
        set_gains(GAIN_MAX, GAIN_MAX);
        for (n = 0; n < 5; n++)
        begin
            steer_heading(FOLD_EDGES[n]);
            send_word(16'sd12000, -16'sd7000, 16'sd20000, 16'sd3000);
        end

        // Random phases; the largest gains also get a long result stall.
        for (phase = 0; phase < GAIN_SETTINGS; phase++)
        begin
            case (phase)
                0:
                begin
                    lin = '0;
                    ang = '0;
                end
                1:
                begin
                    lin = GAIN_MAX;
                    ang = GAIN_MAX;
                end
                2:
                begin
                    lin = LINEAR_GAIN_RESET;
                    ang = ANGULAR_GAIN_RESET;
                end
                3:
                begin
                    lin = $urandom;
                    ang = $urandom;
                end
                default:
                begin
                    lin = $urandom >> $urandom_range(0, 31);
                    ang = $urandom >> $urandom_range(0, 31);
                end
            endcase
            settle();
            set_gains(lin, ang);
            idle_on = (phase != 2);
            if (phase == 1)
                rx_hold_left = HOLD_CYCLES;
            repeat (RANDOM_WORDS / GAIN_SETTINGS) send_random_word();
        end

        // Full forward along the -45 degree diagonal, then back off.
        idle_on = 1'b0;
        settle();
        set_gains(GAIN_MAX, GAIN_MAX);
        steer_heading(DIAGONAL_HEADING);
        repeat (16) send_word(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
        repeat (8) send_word(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);

        settle();
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("Checked %0d pose words over %0d gain writes: field extremes, rounding ties,",
                 tracker.words_seen, gain_settings);
        $display("fold edges, a %0d-cycle result stall, a diagonal run (clamped x %0d, y %0d).",
                 HOLD_CYCLES, tracker.x_clamps, tracker.y_clamps);
        if (tracker.mismatches == 0 && tracker.outstanding() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

[filelist.f]
hdl/moi_pkg.sv
hdl/moi_stream_if.sv
hdl/moi_front.sv
hdl/moi_step_fifo.sv
hdl/moi_back.sv
hdl/mecanum_odometry_integrator_top.sv
tb/testbench.sv
